// ===== hdl/sgnf_pkg.sv =====
// ----------------------------------------------------------------------------
// sgnf_pkg: shared types, constants and kernel weights
// Sizes, widths, controller states and the Sobel weight table used by the
// normalised gradient filter and its divider.
// ----------------------------------------------------------------------------
package sgnf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 5;

  localparam int CFG_W      = 11;                  // widest register
  localparam int CNT_W      = 11;                  // position counters
  localparam int ADDR_W     = $clog2(MAX_WIDTH);   // line store column address
  localparam int LINES      = 4;                   // lines kept in the store
  localparam int WORD_W     = 8 * LINES;           // one column of all lines
  localparam int WIN        = 5;                   // window side
  localparam int WT_W       = 5;                   // signed weight
  localparam int PROD_W     = 14;                  // pixel times weight
  localparam int SUM_W      = 16;                  // row and total sums
  localparam int MAG_W      = 14;                  // divider operand width
  localparam int STEP_W     = $clog2(MAG_W + 1);

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [1:0] REG_DIRECTION    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SUM_ROWS,
    ST_SUM_ALL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [MAG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MAG_W-1:0]  quotient;
  } div_rsp_t;

  // Sobel weight at window tap (y, x); the 3x3 kernel sits in the lower right
  // corner, on the newest three lines and columns
  function automatic logic signed [WT_W-1:0] weight(input logic big, input logic vert,
                                                    input int y, input int x);
    int smooth;
    int grad;
    int a;
    int b;
    a = vert ? x : y;   // smoothing axis
    b = vert ? y : x;   // gradient axis
    smooth = 0;
    grad   = 0;
    if (big) begin
      unique case (a)
        0, 4:    smooth = 1;
        1, 3:    smooth = 2;
        default: smooth = 4;
      endcase
      unique case (b)
        0:       grad = -1;
        1:       grad = -2;
        3:       grad = 2;
        4:       grad = 1;
        default: grad = 0;
      endcase
    end else if (y >= 2 && x >= 2) begin
      smooth = (a == 3) ? 2 : 1;
      unique case (b)
        2:       grad = -1;
        4:       grad = 1;
        default: grad = 0;
      endcase
    end
    return WT_W'(smooth * grad);
  endfunction

  // clamp a size register to [MIN_SIZE, hi]
  function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int hi);
    if (v < CFG_W'(MIN_SIZE)) return CNT_W'(MIN_SIZE);
    if (v > CFG_W'(hi)) return CNT_W'(hi);
    return CNT_W'(v);
  endfunction

endpackage

// ===== hdl/sgnf_if.sv =====
// ----------------------------------------------------------------------------
// sgnf_if: stream channels of the filter
// Pixel input channel and filtered result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgnf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       start_of_frame;
  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface sgnf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered;
  logic       end_of_frame;
  modport source (output valid, output filtered, output end_of_frame, input ready);
  modport sink   (input valid, input filtered, input end_of_frame, output ready);
endinterface

// ===== hdl/sgnf_ram.sv =====
// ----------------------------------------------------------------------------
// sgnf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sgnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sgnf_div.sv =====
// ----------------------------------------------------------------------------
// sgnf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgnf_div (
  input  logic                clk,
  input  logic                rst,
  input  sgnf_pkg::div_req_t  req,
  output sgnf_pkg::div_rsp_t  rsp
);

  logic [sgnf_pkg::MAG_W:0]    rem;
  logic [sgnf_pkg::MAG_W-1:0]  quo;
  logic [sgnf_pkg::MAG_W-1:0]  dvs;
  logic [sgnf_pkg::STEP_W-1:0] steps;
  logic                        busy;
  logic                        done;
  logic [sgnf_pkg::MAG_W:0]    trial;

  assign trial = {rem[sgnf_pkg::MAG_W-1:0], quo[sgnf_pkg::MAG_W-1]};

  // run one restoring step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        rem   <= '0;
        quo   <= req.dividend;
        dvs   <= req.divisor;
        steps <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[sgnf_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[sgnf_pkg::MAG_W-2:0], 1'b0};
        end
        steps <= steps + 1'b1;
        if (steps == sgnf_pkg::STEP_W'(sgnf_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== hdl/sobel_gradient_normalized_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_normalized_filter_unit: normalised Sobel gradient filter
// Line store in RAM, 5x5 window, row sum tree and iterative divider.
// ----------------------------------------------------------------------------
// Usage
//   pix carries one grey pixel per word in raster order; start_of_frame on a
//   word restarts the position counters at row 0, column 0. res carries one
//   filtered word per pixel that completes a full window; end_of_frame marks
//   the last one of a frame. Other pixels give no word.
//   One pixel is in work at a time. Each pixel passes through the RAM
//   read-modify-write of the line store column and the two-stage tap sum;
//   a pixel that yields no word then returns to idle, and one that yields a
//   word goes on through the 14 divider steps with their done flag and the
//   output load.
//   The next pixel is taken as soon as the previous one is finished, even if
//   its result word still waits in the output register.
//   The configuration port writes image_width, image_height, kernel_size and
//   direction by index; write only while the block is idle.
//   Reset clears counters, window, state and output valid; the line store
//   needs no clearing. When res is stalled the finished result is held in the
//   output register and the block stops before loading the next one.
// ----------------------------------------------------------------------------
module sobel_gradient_normalized_filter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [sgnf_pkg::CFG_W-1:0]   cfg_data,
  sgnf_pix_if.sink                     pix,
  sgnf_res_if.source                   res
);

  localparam int W = sgnf_pkg::WIN;

  // configuration registers
  logic [sgnf_pkg::CFG_W-1:0] image_width;
  logic [sgnf_pkg::CFG_W-1:0] image_height;
  logic                       kernel_size;
  logic                       direction;

  sgnf_pkg::state_t state, state_next;

  logic [7:0]                 px;
  logic                       sof;
  logic [sgnf_pkg::CNT_W-1:0] column_count;
  logic [sgnf_pkg::CNT_W-1:0] row_count;
  logic [sgnf_pkg::CNT_W-1:0] cur_col;
  logic [sgnf_pkg::CNT_W-1:0] cur_row;
  logic [sgnf_pkg::CNT_W-1:0] pre_col;
  logic [sgnf_pkg::CNT_W-1:0] pre_row;
  logic [sgnf_pkg::CNT_W-1:0] eff_w;
  logic [sgnf_pkg::CNT_W-1:0] eff_h;
  logic [sgnf_pkg::CNT_W-1:0] next_col;
  logic [sgnf_pkg::CNT_W-1:0] next_row;
  logic                       has_result;
  logic                       eof;

  logic [7:0] win [W][W];

  logic                        ram_we;
  logic [sgnf_pkg::ADDR_W-1:0] ram_raddr;
  logic [sgnf_pkg::WORD_W-1:0] ram_rdata;
  logic [sgnf_pkg::WORD_W-1:0] ram_wdata;

  logic signed [sgnf_pkg::SUM_W-1:0] row_resp [W];
  logic signed [sgnf_pkg::SUM_W-1:0] row_pos  [W];
  logic signed [sgnf_pkg::SUM_W-1:0] row_resp_next [W];
  logic signed [sgnf_pkg::SUM_W-1:0] row_pos_next  [W];
  logic signed [sgnf_pkg::SUM_W-1:0] resp_next;
  logic signed [sgnf_pkg::SUM_W-1:0] pos_next;
  logic                              resp_neg;

  sgnf_pkg::div_req_t div_req;
  sgnf_pkg::div_rsp_t div_rsp;
  logic [7:0]                 half_q;

  logic       out_valid;
  logic [7:0] out_filtered;
  logic       out_eof;
  logic       out_load;

  assign eff_w = sgnf_pkg::clamp_size(image_width, sgnf_pkg::MAX_WIDTH);
  assign eff_h = sgnf_pkg::clamp_size(image_height, sgnf_pkg::MAX_HEIGHT);

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sgnf_pkg::CFG_W'(sgnf_pkg::MAX_WIDTH);
      image_height <= sgnf_pkg::CFG_W'(sgnf_pkg::MAX_HEIGHT);
      kernel_size  <= 1'b0;
      direction    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sgnf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        sgnf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        sgnf_pkg::REG_KERNEL_SIZE:  kernel_size  <= cfg_data[0];
        sgnf_pkg::REG_DIRECTION:    direction    <= cfg_data[0];
      endcase
    end
  end

  // position of this pixel, with frame restart and wrap
  always_comb begin
    pre_col = sof ? '0 : column_count;
    pre_row = sof ? '0 : row_count;
    if (pre_col >= eff_w) begin
      pre_col = '0;
      pre_row = pre_row + 1'b1;
    end
    if (pre_row >= eff_h) begin
      pre_row = '0;
    end
  end

  // position of the next pixel
  always_comb begin
    next_col = cur_col + 1'b1;
    next_row = cur_row;
    if (next_col >= eff_w) begin
      next_col = '0;
      next_row = cur_row + 1'b1;
      if (next_row >= eff_h) begin
        next_row = '0;
      end
    end
  end

  // line store: one word per column, one byte per line slot
  assign ram_raddr = pre_col[sgnf_pkg::ADDR_W-1:0];
  assign ram_we    = (state == sgnf_pkg::ST_LOAD);

  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[8*cur_row[1:0] +: 8] = px;
  end

  sgnf_ram #(
    .WIDTH (sgnf_pkg::WORD_W),
    .DEPTH (sgnf_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col[sgnf_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-row weighted sums, all taps and positive taps; skip zero-weight taps
  always_comb begin
    logic signed [sgnf_pkg::PROD_W-1:0] prod;
    logic signed [sgnf_pkg::WT_W-1:0]   wt;
    for (int y = 0; y < W; y++) begin
      row_resp_next[y] = '0;
      row_pos_next[y]  = '0;
      for (int x = 0; x < W; x++) begin
        wt   = sgnf_pkg::weight(kernel_size, direction, y, x);
        prod = '0;
        if (wt != 0) begin
          prod = sgnf_pkg::PROD_W'($signed({1'b0, win[y][x]})) * sgnf_pkg::PROD_W'(wt);
          row_resp_next[y] = row_resp_next[y] + sgnf_pkg::SUM_W'(prod);
          if (wt > 0) begin
            row_pos_next[y] = row_pos_next[y] + sgnf_pkg::SUM_W'(prod);
          end
        end
      end
    end
  end

  // add the row sums
  always_comb begin
    resp_next = '0;
    pos_next  = '0;
    for (int y = 0; y < W; y++) begin
      resp_next = resp_next + row_resp[y];
      pos_next  = pos_next + row_pos[y];
    end
  end

  // hold the sign of the response for the final offset
  always_ff @(posedge clk) begin
    if (state == sgnf_pkg::ST_SUM_ALL) begin
      resp_neg <= resp_next < 0;
    end
  end

  // divider operands: magnitude of response, zero divisor taken as one
  assign div_req.start    = (state == sgnf_pkg::ST_SUM_ALL) && has_result;
  assign div_req.dividend = sgnf_pkg::MAG_W'(resp_next < 0 ? -resp_next : resp_next);
  assign div_req.divisor  = (pos_next == 0) ? sgnf_pkg::MAG_W'(1)
                                            : sgnf_pkg::MAG_W'(pos_next);

  sgnf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // halve toward zero and offset by 128
  logic [7:0] quo_word;
  assign half_q   = div_rsp.quotient[8:1];
  assign quo_word = resp_neg ? 8'd128 - half_q : 8'd128 + half_q;

  // next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      sgnf_pkg::ST_IDLE:     if (pix.valid) state_next = sgnf_pkg::ST_READ;
      sgnf_pkg::ST_READ:     state_next = sgnf_pkg::ST_LOAD;
      sgnf_pkg::ST_LOAD:     state_next = sgnf_pkg::ST_SUM_ROWS;
      sgnf_pkg::ST_SUM_ROWS: state_next = sgnf_pkg::ST_SUM_ALL;
      sgnf_pkg::ST_SUM_ALL:  state_next = has_result ? sgnf_pkg::ST_DIV : sgnf_pkg::ST_IDLE;
      sgnf_pkg::ST_DIV:      if (div_rsp.done) state_next = sgnf_pkg::ST_OUT;
      sgnf_pkg::ST_OUT: begin
        if (!out_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = sgnf_pkg::ST_IDLE;
        end
      end
      default:               state_next = sgnf_pkg::ST_IDLE;
    endcase
  end

  assign pix.ready = (state == sgnf_pkg::ST_IDLE);

  // hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgnf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // take the input word
  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      px  <= pix.pixel;
      sof <= pix.start_of_frame;
    end
  end

  // latch position, then advance counters and shift the window
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int y = 0; y < W; y++) begin
        for (int x = 0; x < W; x++) begin
          win[y][x] <= '0;
        end
      end
    end else begin
      if (state == sgnf_pkg::ST_READ) begin
        cur_col <= pre_col;
        cur_row <= pre_row;
      end
      if (state == sgnf_pkg::ST_LOAD) begin
        column_count <= next_col;
        row_count    <= next_row;
        has_result   <= kernel_size ? (cur_row >= 11'd4 && cur_col >= 11'd4)
                                    : (cur_row >= 11'd2 && cur_col >= 11'd2);
        eof          <= (cur_row == eff_h - 1'b1) && (cur_col == eff_w - 1'b1);
        for (int y = 0; y < W; y++) begin
          for (int x = 0; x < W - 1; x++) begin
            win[y][x] <= win[y][x+1];
          end
        end
        for (int y = 0; y < W - 1; y++) begin
          win[y][W-1] <= ram_rdata[8*(2'(cur_row[1:0] + 2'(y))) +: 8];
        end
        win[W-1][W-1] <= px;
      end
    end
  end

  // register row sums
  always_ff @(posedge clk) begin
    if (state == sgnf_pkg::ST_SUM_ROWS) begin
      for (int y = 0; y < W; y++) begin
        row_resp[y] <= row_resp_next[y];
        row_pos[y]  <= row_pos_next[y];
      end
    end
  end

  // output register: load a finished word, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered <= quo_word;
      out_eof      <= eof;
    end
  end

  assign res.valid        = out_valid;
  assign res.filtered     = out_filtered;
  assign res.end_of_frame = out_eof;

endmodule

// ===== verif/sgnf_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgnf_tb_if: note on channel interfaces
// The pixel and result channels are the interfaces of the RTL (sgnf_pix_if,
// sgnf_res_if); this file holds the word types the bench keeps in its queues.
// ----------------------------------------------------------------------------
package sgnf_tb_pkg;

  typedef struct packed {
    logic [7:0] filtered;
    logic       end_of_frame;
  } res_word_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_of_frame;
  } pix_word_t;

endpackage

// ===== verif/sobel_gradient_normalized_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_normalized_filter_unit_tb: self-checking bench of the filter
// Streams frames of pixels under several size and kernel settings, predicts
// every filtered word with a behavioural filter and compares it field by field.
// ----------------------------------------------------------------------------
module sobel_gradient_normalized_filter_unit_tb;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [1:0]                  cfg_index;
  logic [sgnf_pkg::CFG_W-1:0]  cfg_data;

  sgnf_pix_if pix ();
  sgnf_res_if res ();

  sobel_gradient_normalized_filter_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix), .res(res)
  );

  // predictor state
  logic [10:0] img_w, img_h;
  logic        big_kernel, vertical;
  logic [7:0]  line_mem [4*sgnf_pkg::MAX_WIDTH];
  logic [7:0]  win [5][5];
  int          col_pos, row_pos;
  int          typed_word;

  sgnf_tb_pkg::res_word_t expected_q[$];
  int          errors, pixels_sent, words_seen, frames_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("sobel_gradient_normalized_filter_unit_tb failed");
    $finish;
  end

  function automatic int eff_size(input logic [10:0] v, input int hi);
    if (v < 5) return 5;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int sobel_weight(input bit b, input bit v, input int y, input int x);
    int sm, gr, a, g;
    a = v ? x : y;
    g = v ? y : x;
    if (b) begin
      sm = (a == 2) ? 4 : ((a == 1 || a == 3) ? 2 : 1);
      gr = (g == 0) ? -1 : (g == 1) ? -2 : (g == 3) ? 2 : (g == 4) ? 1 : 0;
    end else begin
      sm = (a == 1) ? 2 : 1;
      gr = (g == 0) ? -1 : (g == 2) ? 1 : 0;
    end
    return sm * gr;
  endfunction

  // advance the behavioural filter by one pixel; queue the word it yields
  task automatic filter_pixel(input sgnf_tb_pkg::pix_word_t p);
    int w, h, n, off, resp, pos, q, wt, pv;
    sgnf_tb_pkg::res_word_t r;
    w = eff_size(img_w, sgnf_pkg::MAX_WIDTH);
    h = eff_size(img_h, sgnf_pkg::MAX_HEIGHT);
    if (p.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
    for (int y = 0; y < 4; y++)
      win[y][4] = line_mem[((row_pos + y) & 3) * sgnf_pkg::MAX_WIDTH + col_pos];
    win[4][4] = p.pixel;
    line_mem[(row_pos & 3) * sgnf_pkg::MAX_WIDTH + col_pos] = p.pixel;
    n = big_kernel ? 5 : 3;
    if (row_pos >= n - 1 && col_pos >= n - 1) begin
      off = 5 - n;
      resp = 0;
      pos = 0;
      for (int y = 0; y < n; y++)
        for (int x = 0; x < n; x++) begin
          wt = sobel_weight(big_kernel, vertical, y, x);
          pv = win[off+y][off+x];
          resp += pv * wt;
          if (wt > 0) pos += pv * wt;
        end
      if (pos == 0) pos = 1;
      q = 128 + (resp / pos) / 2;
      r.filtered = (typed_word >= 0) ? 8'(typed_word) : q[7:0];
      r.end_of_frame = (row_pos == h - 1 && col_pos == w - 1);
      expected_q.push_back(r);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // write one register on the idle block
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      sgnf_pkg::REG_IMAGE_WIDTH:  img_w = val;
      sgnf_pkg::REG_IMAGE_HEIGHT: img_h = val;
      sgnf_pkg::REG_KERNEL_SIZE:  big_kernel = val[0];
      sgnf_pkg::REG_DIRECTION:    vertical = val[0];
    endcase
  endtask

  // send one word; called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [7:0] px, input logic sof);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 5));
    if (pix.valid && gap != 0) pix.valid <= 1'b0;
    repeat (gap) @(negedge clk);
    pix.valid <= 1'b1;
    pix.pixel <= px;
    pix.start_of_frame <= sof;
    do @(posedge clk); while (!pix.ready);
    filter_pixel('{pixel: px, start_of_frame: sof});
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // send a frame of pixels; shade selects flat, extreme or random content
  task automatic send_frame(input int pixels, input int shade);
    logic [7:0] px;
    for (int i = 0; i < pixels; i++) begin
      case (shade)
        0: px = 8'd0;
        1: px = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
        default: px = 8'($urandom_range(0, 255));
      endcase
      send_pixel(px, i == 0 || ($urandom_range(0, 199) == 0));
    end
  endtask

  // result side: hold off each word by a random delay, then take it
  initial begin
    int hold;
    res.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      hold = $urandom_range(0, 5);
      if (hold != 0) begin
        res.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  // compare each taken word against the oldest expectation
  always @(posedge clk) begin
    sgnf_tb_pkg::res_word_t e;
    if (!rst && res.valid && res.ready) begin
      words_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected word filtered=%0d end_of_frame=%0b", res.filtered, res.end_of_frame);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res.filtered !== e.filtered) begin
          $error("filtered: expected %0d, actual %0d", e.filtered, res.filtered);
          errors++;
        end
        if (res.end_of_frame !== e.end_of_frame) begin
          $error("end_of_frame: expected %0b, actual %0b", e.end_of_frame, res.end_of_frame);
          errors++;
        end
        if (e.end_of_frame) frames_seen++;
      end
    end
  end

  // directed rows: width, height, kernel, direction, shade, typed word (-1: predicted)
  typedef struct {
    int w;
    int h;
    bit k;
    bit d;
    int shade;
    int word;
  } phase_t;

  phase_t phases[] = '{
    '{5, 5, 0, 0, 0, 128}, '{5, 5, 1, 1, 1, -1}, '{6, 5, 0, 1, 1, -1},
    '{5, 6, 1, 0, 1, -1}, '{3, 2000, 0, 0, 2, -1}, '{9, 2047, 1, 1, 2, -1},
    '{0, 0, 1, 0, 2, -1}
  };

  initial begin
    int w, h, k;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = sgnf_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    pix.start_of_frame = 1'b0;
    img_w = 11'd1024;
    img_h = 11'd1024;
    big_kernel = 1'b0;
    vertical = 1'b0;
    col_pos = 0;
    row_pos = 0;
    typed_word = -1;
    foreach (win[y, x]) win[y][x] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    errors = 0;
    pixels_sent = 0;
    words_seen = 0;
    frames_seen = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first pixels under reset settings: no full window yet, so no word
    send_frame(8, 0);
    drain_and_idle();

    // directed settings, extremes and out-of-range sizes among them
    foreach (phases[i]) begin
      write_reg(sgnf_pkg::REG_IMAGE_WIDTH, 11'(phases[i].w));
      write_reg(sgnf_pkg::REG_IMAGE_HEIGHT, 11'(phases[i].h));
      write_reg(sgnf_pkg::REG_KERNEL_SIZE, 11'(phases[i].k));
      write_reg(sgnf_pkg::REG_DIRECTION, 11'(phases[i].d));
      w = eff_size(11'(phases[i].w), sgnf_pkg::MAX_WIDTH);
      h = eff_size(11'(phases[i].h), sgnf_pkg::MAX_HEIGHT);
      typed_word = phases[i].word;
      send_frame((w * h > 60) ? w * 5 : w * h, phases[i].shade);
      drain_and_idle();
    end
    typed_word = -1;

    // random frames of small sizes, full frames so that end_of_frame appears
    while (pixels_sent < 1560) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 9);
      write_reg(sgnf_pkg::REG_IMAGE_WIDTH, 11'(w));
      write_reg(sgnf_pkg::REG_IMAGE_HEIGHT, 11'(h));
      write_reg(sgnf_pkg::REG_KERNEL_SIZE, 11'($urandom_range(0, 1)));
      write_reg(sgnf_pkg::REG_DIRECTION, 11'($urandom_range(0, 1)));
      k = $urandom_range(1, 3);
      send_frame(w * h * k + int'($urandom_range(0, w)), int'($urandom_range(1, 4)));
      drain_and_idle();
    end

    $display("%0d pixels sent, %0d words checked, %0d frame ends seen",
             pixels_sent, words_seen, frames_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("sobel_gradient_normalized_filter_unit_tb passed");
    else
      $display("sobel_gradient_normalized_filter_unit_tb failed");
    $finish;
  end

endmodule
